### sv/rmts_pkg.sv
// Shared types and constants for the rate-monotonic tick scheduler.
// No dependencies; used by rmts_cell and rate_monotonic_tick_scheduler.
`default_nettype none
package rmts_pkg;

    localparam int NUM_SLOTS = 8;                       // slots that take part
    localparam int SLOT_CAP  = 8;                       // registers on the config port
    localparam int IDX_W     = $clog2(SLOT_CAP);        // slot index / config index
    localparam int WORD_W    = 16;                      // task word
    localparam int VAL_W     = 8;                       // period, exec time, counters
    localparam int SLOT_W    = 4;                       // running_slot field
    localparam int SCAN_W    = $clog2(NUM_SLOTS + 1);   // scan cycle counter

    // best-candidate token walking down the chain
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] period;
    } token_t;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic             arrive;
        logic             restart;
        logic             commit;
        logic [IDX_W-1:0] win_idx;
    } cell_ctrl_t;

endpackage
`default_nettype wire

### sv/rate_monotonic_tick_scheduler.sv
// Top level: tick sequencer, output register and the chain of slot cells.
// Depends on rmts_pkg and rmts_cell.
//
//   channel   direction  ports
//   s_        in         s_valid, s_ready, s_restart
//   m_        out        m_valid, m_ready, m_running_slot, m_miss_mask
//   cfg_      in         cfg_we, cfg_index, cfg_wdata (write only)
//
// In a tick, the accept edge applies restart and arrivals in every cell,
// the selection token then walks the cell chain one cell per cycle, and the
// commit state charges the winner and loads the output.
// One tick at a time; s_ready is high only while the sequencer is idle.
// A held result stalls the commit step until m_ready takes it.
// aresetn is synchronous and clears config words and all job state.
`default_nettype none
module rate_monotonic_tick_scheduler (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        cfg_we,
    input  wire [rmts_pkg::IDX_W-1:0]  cfg_index,
    input  wire [rmts_pkg::WORD_W-1:0] cfg_wdata,
    input  wire                        s_valid,
    output logic                       s_ready,
    input  wire                        s_restart,
    output logic                       m_valid,
    input  wire                        m_ready,
    output logic [rmts_pkg::SLOT_W-1:0]   m_running_slot,
    output logic [rmts_pkg::SLOT_CAP-1:0] m_miss_mask
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0]                    state_reg, state_next;
    logic [rmts_pkg::SCAN_W-1:0]   scan_reg, scan_next;
    logic                          m_valid_reg, m_valid_next;
    logic [rmts_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic [rmts_pkg::SLOT_CAP-1:0] mask_reg, mask_next;

    rmts_pkg::token_t              chain [rmts_pkg::NUM_SLOTS+1];
    logic [rmts_pkg::NUM_SLOTS-1:0] miss_bits;
    rmts_pkg::cell_ctrl_t          ctrl;
    logic                          accept, commit_ok;
    rmts_pkg::token_t              best;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign best      = chain[rmts_pkg::NUM_SLOTS];
    assign commit_ok = (state_reg == ST_COMMIT) && (!m_valid_reg || m_ready);

    always_comb begin
        ctrl.arrive  = accept;
        ctrl.restart = accept && s_restart;
        ctrl.commit  = commit_ok && best.found;
        ctrl.win_idx = best.idx;
    end

    assign chain[0] = '0;

    genvar k;
    generate
        for (k = 0; k < rmts_pkg::NUM_SLOTS; k++) begin : g_cell
            rmts_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .slot_idx  (rmts_pkg::IDX_W'(k)),
                .cfg_we    (cfg_we && (cfg_index == rmts_pkg::IDX_W'(k))),
                .cfg_wdata (cfg_wdata),
                .ctrl      (ctrl),
                .token_in  (chain[k]),
                .token_out (chain[k+1]),
                .miss      (miss_bits[k])
            );
        end
    endgenerate

    always_comb begin
        state_next   = state_reg;
        scan_next    = scan_reg;
        m_valid_next = m_valid_reg;
        slot_next    = slot_reg;
        mask_next    = mask_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_SCAN;
                    scan_next  = '0;
                end
            end
            ST_SCAN: begin
                // token reaches the chain end as the last scan step hands over to commit
                if (scan_reg == rmts_pkg::SCAN_W'(rmts_pkg::NUM_SLOTS - 1)) begin
                    state_next = ST_COMMIT;
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_COMMIT: begin
                if (commit_ok) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                    slot_next    = best.found
                                 ? rmts_pkg::SLOT_W'(best.idx) + 1'b1
                                 : '0;
                    mask_next    = rmts_pkg::SLOT_CAP'(miss_bits);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            scan_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            scan_reg    <= scan_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
        mask_reg <= mask_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_running_slot = slot_reg;
    assign m_miss_mask    = mask_reg;

endmodule
`default_nettype wire

### sv/rmts_cell.sv
// One task slot: config word, remaining work, arrival countdown, miss flag,
// and one stage of the priority-selection chain. Depends on rmts_pkg.
`default_nettype none
module rmts_cell (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire [rmts_pkg::IDX_W-1:0]  slot_idx,
    input  wire                        cfg_we,
    input  wire [rmts_pkg::WORD_W-1:0] cfg_wdata,
    input  rmts_pkg::cell_ctrl_t       ctrl,
    input  rmts_pkg::token_t           token_in,
    output rmts_pkg::token_t           token_out,
    output logic                       miss
);

    logic [rmts_pkg::WORD_W-1:0] word_reg;
    logic [rmts_pkg::VAL_W-1:0]  work_reg, work_next;
    logic [rmts_pkg::VAL_W-1:0]  cnt_reg, cnt_next;
    logic                        miss_reg, miss_next;
    rmts_pkg::token_t            token_reg, token_next;

    logic [rmts_pkg::VAL_W-1:0]  period, exec_time, work_cur, cnt_cur;
    logic                        active, take;

    assign period    = word_reg[rmts_pkg::WORD_W-1:rmts_pkg::VAL_W];
    assign exec_time = word_reg[rmts_pkg::VAL_W-1:0];
    assign active    = (period != '0) && (exec_time != '0);
    assign work_cur  = ctrl.restart ? '0 : work_reg;
    assign cnt_cur   = ctrl.restart ? '0 : cnt_reg;

    always_comb begin
        work_next = work_reg;
        cnt_next  = cnt_reg;
        miss_next = miss_reg;
        if (ctrl.arrive) begin
            miss_next = 1'b0;
            if (!active) begin
                work_next = '0;
                cnt_next  = '0;
            end else if (cnt_cur == '0) begin
                miss_next = (work_cur != '0);   // previous job replaced
                work_next = exec_time;
                cnt_next  = period - 1'b1;
            end else begin
                work_next = work_cur;
                cnt_next  = cnt_cur - 1'b1;
            end
        end else if (ctrl.commit && (ctrl.win_idx == slot_idx)) begin
            work_next = work_reg - 1'b1;
        end
    end

    // strict less-than keeps the lower slot on ties
    assign take = (work_reg != '0) && (!token_in.found || (period < token_in.period));

    always_comb begin
        token_next = token_in;
        if (take) begin
            token_next.found  = 1'b1;
            token_next.idx    = slot_idx;
            token_next.period = period;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg  <= '0;
            work_reg  <= '0;
            cnt_reg   <= '0;
            miss_reg  <= 1'b0;
            token_reg <= '0;
        end else begin
            if (cfg_we) begin
                word_reg <= cfg_wdata;
            end
            work_reg  <= work_next;
            cnt_reg   <= cnt_next;
            miss_reg  <= miss_next;
            token_reg <= token_next;
        end
    end

    assign token_out = token_reg;
    assign miss      = miss_reg;

endmodule
`default_nettype wire
